FILE: rtl/dtc_pkg.sv
`default_nettype none

package dtc_pkg;

   // time format and day length
   localparam int FRACTION_BITS = 16;
   localparam int TIME_W        = 33;
   localparam int ELAPSED_W     = 18;
   localparam int GAIN_W        = 16;
   localparam int THR_W         = 32;
   localparam int DIFF_W        = TIME_W + 2;
   localparam longint DAY_INT   = 64'd86400 << FRACTION_BITS;
   localparam int MAG_W         = $clog2(DAY_INT / 2 + 1);

   localparam logic [TIME_W-1:0]        DAY_UNITS     = TIME_W'(DAY_INT);
   localparam logic signed [DIFF_W-1:0] DAY_DIFF      = DIFF_W'(DAY_INT);
   localparam logic signed [DIFF_W-1:0] HALF_DIFF     = DIFF_W'(DAY_INT / 2);
   localparam logic signed [DIFF_W-1:0] NEG_HALF_DIFF = -HALF_DIFF;

   localparam int PROD_W = MAG_W + GAIN_W;
   localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (GAIN_W - 1);

   // register reset values
   localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd8423;
   localparam logic [THR_W-1:0]  THR_RESET  = 32'd196608;

   // configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_EASE_GAIN = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RESYNC    = 1'd1;

   // time of day split
   localparam int SECS_W       = TIME_W - FRACTION_BITS;
   localparam int HOUR_W       = 5;
   localparam int MIN_W        = 6;
   localparam int SEC_W        = 6;
   localparam int Q60_W        = 11;
   localparam int RECIP_W      = 18;
   localparam int SPLIT_PROD_W = SECS_W + RECIP_W;
   localparam int SHIFT60      = 23;
   localparam int SHIFT3600    = 29;
   localparam logic [SPLIT_PROD_W-1:0] RECIP60 =
      SPLIT_PROD_W'(((64'd1 << SHIFT60) + 64'd59) / 64'd60);
   localparam logic [SPLIT_PROD_W-1:0] RECIP3600 =
      SPLIT_PROD_W'(((64'd1 << SHIFT3600) + 64'd3599) / 64'd3600);
   localparam int SIXTY = 60;

   // stream packing
   localparam int REQ_FIELDS_W = 1 + TIME_W + ELAPSED_W;
   localparam int REQ_TDATA_W  = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = HOUR_W + MIN_W + SEC_W;
   localparam int RSP_TDATA_W  = ((RSP_FIELDS_W + 7) / 8) * 8;

   typedef struct packed {
      logic                 link_up;
      logic                 target_update;
      logic [TIME_W-1:0]    target_time;
      logic [ELAPSED_W-1:0] elapsed;
   } req_item_type;

   typedef struct packed {
      logic [TIME_W-1:0] display;
      logic              clock_valid;
   } core_out_type;

   typedef struct packed {
      logic [HOUR_W-1:0] hour;
      logic [MIN_W-1:0]  minute;
      logic [SEC_W-1:0]  second;
      logic              clock_valid;
   } rsp_item_type;

endpackage

`default_nettype wire

FILE: rtl/disciplined_time_of_day_clock.sv
// Disciplined time-of-day clock.
//
// Requests arrive on the req_ stream, one per tick: link-up flag, elapsed
// time and an optional new reference time (req_tuser marks it as carried).
// Each request yields exactly one response on the rsp_ stream with hour,
// minute and whole second of the displayed time; rsp_tuser says whether any
// reference has been seen. The user must write the registers (gain, resync
// threshold) on the csr_ port while the block is idle; nothing enforces it.
//
// Throughput: one request per clock cycle while the receiver takes responses.
// The figure is set by the display update loop in the core, which adds the
// elapsed time, takes the shortest error, multiplies by the gain or snaps to
// the reference, and wraps at one day combinationally. A response passes the
// input register, display update, seconds split and response register.
//
// Reset clears the display, reference, priming and all valid flags and
// loads the register defaults. When the receiver stalls, the response is
// held and the pipeline keeps taking requests until every stage is full.
`default_nettype none

module disciplined_time_of_day_clock
   import dtc_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_we,
   input  wire logic [CSR_IDX_W-1:0]   csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // link_up, target_time, elapsed, zero pad
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   // target_update
   input  wire logic                   req_tuser,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // hour, minute, second, zero pad
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,
   // clock_valid
   output logic                        rsp_tuser
);

   logic              a_valid_ff, a_valid_in;
   req_item_type      a_item_ff, a_item_in;
   logic              req_fire;
   logic              core_ready, core_valid, hms_ready;
   logic [TIME_W-1:0] target_raw;
   core_out_type      core_item;
   rsp_item_type      rsp_item;

   assign req_tready = !a_valid_ff || core_ready;
   assign req_fire   = req_tvalid && req_tready;

   // unpack the request and fold the reference into one day
   always_comb begin
      target_raw              = req_tdata[1 +: TIME_W];
      a_item_in.link_up       = req_tdata[0];
      a_item_in.target_update = req_tuser;
      a_item_in.target_time   = (target_raw >= DAY_UNITS) ? target_raw - DAY_UNITS
                                                          : target_raw;
      a_item_in.elapsed       = req_tdata[1 + TIME_W +: ELAPSED_W];
      a_valid_in = a_valid_ff;
      if (req_fire) begin
         a_valid_in = 1'b1;
      end else if (core_ready) begin
         a_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   // hold the request payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         a_item_ff <= a_item_in;
      end
   end

   dtc_core u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .in_valid  (a_valid_ff),
      .in_ready  (core_ready),
      .in_item   (a_item_ff),
      .out_valid (core_valid),
      .out_ready (hms_ready),
      .out_item  (core_item)
   );

   dtc_hms u_hms (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (core_valid),
      .in_ready  (hms_ready),
      .in_item   (core_item),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (rsp_item)
   );

   // pack the response
   assign rsp_tdata = {(RSP_TDATA_W-RSP_FIELDS_W)'(0), rsp_item.second,
                       rsp_item.minute, rsp_item.hour};
   assign rsp_tuser = rsp_item.clock_valid;

endmodule

`default_nettype wire

FILE: rtl/dtc_core.sv
`default_nettype none

module dtc_core
   import dtc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                  in_valid,
   output logic                       in_ready,
   input  wire req_item_type          in_item,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output core_out_type               out_item
);

   logic [GAIN_W-1:0] gain_ff, gain_in;
   logic [THR_W-1:0]  thr_ff, thr_in;
   logic [TIME_W-1:0] display_ff, display_in;
   logic [TIME_W-1:0] ref_ff, ref_in;
   logic              have_ff, have_in;
   logic              primed_ff, primed_in;
   logic              valid_ff, valid_in;

   logic                     fire;
   logic [TIME_W-1:0]        ref_sel;
   logic                     have_sel;
   logic [TIME_W:0]          disp_run;
   logic signed [DIFF_W-1:0] diff_raw, diff_adj, mag_full, eased, pre_wrap, wrapped;
   logic [MAG_W-1:0]         mag, step;
   logic [PROD_W-1:0]        prod, rounded;
   logic                     snap;
   logic [TIME_W-1:0]        new_disp;

   assign in_ready = !valid_ff || out_ready;
   assign fire     = in_valid && in_ready;

   // capture the new reference first
   assign ref_sel  = in_item.target_update ? in_item.target_time : ref_ff;
   assign have_sel = have_ff || in_item.target_update;

   // free-run, take the error along the shortest way round the day
   always_comb begin
      disp_run = {1'b0, display_ff} + (TIME_W+1)'(in_item.elapsed);
      diff_raw = $signed(DIFF_W'(ref_sel)) - $signed(DIFF_W'(disp_run));
      if (diff_raw > HALF_DIFF) begin
         diff_adj = diff_raw - DAY_DIFF;
      end else if (diff_raw < NEG_HALF_DIFF) begin
         diff_adj = diff_raw + DAY_DIFF;
      end else begin
         diff_adj = diff_raw;
      end
      mag_full = diff_adj[DIFF_W-1] ? -diff_adj : diff_adj;
      mag      = mag_full[MAG_W-1:0];
   end

   // ease by the gain, rounding half away from zero, or snap
   always_comb begin
      prod    = PROD_W'(mag) * PROD_W'(gain_ff);
      rounded = prod + ROUND_HALF;
      step    = rounded[GAIN_W +: MAG_W];
      snap    = mag > thr_ff;
      if (diff_adj[DIFF_W-1]) begin
         eased = $signed(DIFF_W'(disp_run)) - $signed(DIFF_W'(step));
      end else begin
         eased = $signed(DIFF_W'(disp_run)) + $signed(DIFF_W'(step));
      end
      pre_wrap = snap ? $signed(DIFF_W'(ref_sel)) : eased;
      if (pre_wrap < 0) begin
         wrapped = pre_wrap + DAY_DIFF;
      end else if (pre_wrap >= DAY_DIFF) begin
         wrapped = pre_wrap - DAY_DIFF;
      end else begin
         wrapped = pre_wrap;
      end
      new_disp = wrapped[TIME_W-1:0];
   end

   // next state
   always_comb begin
      gain_in    = gain_ff;
      thr_in     = thr_ff;
      display_in = display_ff;
      ref_in     = ref_ff;
      have_in    = have_ff;
      primed_in  = primed_ff;
      valid_in   = valid_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_EASE_GAIN: gain_in = csr_wdata[GAIN_W-1:0];
            CSR_RESYNC:    thr_in  = csr_wdata[THR_W-1:0];
            default: ;
         endcase
      end
      if (fire) begin
         valid_in = 1'b1;
         ref_in   = ref_sel;
         have_in  = have_sel;
         if (!in_item.link_up) begin
            primed_in = 1'b0;
         end else if (have_sel) begin
            primed_in  = 1'b1;
            display_in = primed_ff ? new_disp : ref_sel;
         end
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff    <= GAIN_RESET;
         thr_ff     <= THR_RESET;
         display_ff <= '0;
         ref_ff     <= '0;
         have_ff    <= 1'b0;
         primed_ff  <= 1'b0;
         valid_ff   <= 1'b0;
      end else begin
         gain_ff    <= gain_in;
         thr_ff     <= thr_in;
         display_ff <= display_in;
         ref_ff     <= ref_in;
         have_ff    <= have_in;
         primed_ff  <= primed_in;
         valid_ff   <= valid_in;
      end
   end

   assign out_valid            = valid_ff;
   assign out_item.display     = display_ff;
   assign out_item.clock_valid = have_ff;

   // display always stays inside one day
   a_display_in_day: assert property (@(posedge clock) disable iff (reset)
      display_ff < DAY_UNITS)
      else $error("display time outside one day");

   // priming needs a reference
   a_primed_has_ref: assert property (@(posedge clock) disable iff (reset)
      primed_ff |-> have_ff)
      else $error("primed without a reference");

   // display moves only on an accepted request
   a_display_holds: assert property (@(posedge clock) disable iff (reset)
      (!fire && !reset) |=> $stable(display_ff))
      else $error("display changed without a request");

endmodule

`default_nettype wire

FILE: rtl/dtc_hms.sv
`default_nettype none

module dtc_hms
   import dtc_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         in_valid,
   output logic              in_ready,
   input  wire core_out_type in_item,
   output logic              out_valid,
   input  wire logic         out_ready,
   output rsp_item_type      out_item
);

   logic                    c_valid_ff, c_valid_in;
   logic [SECS_W-1:0]       c_total_ff;
   logic [Q60_W-1:0]        c_q60_ff;
   logic [HOUR_W-1:0]       c_hour_ff;
   logic                    c_cv_ff;
   logic                    d_valid_ff, d_valid_in;
   rsp_item_type            d_item_ff, d_item_in;

   logic                    c_ready, d_ready, c_fire, d_fire;
   logic [SECS_W-1:0]       total;
   logic [SPLIT_PROD_W-1:0] p60, p3600;
   logic [Q60_W-1:0]        min_full;
   logic [SECS_W-1:0]       sec_full;

   assign d_ready  = !d_valid_ff || out_ready;
   assign c_ready  = !c_valid_ff || d_ready;
   assign in_ready = c_ready;
   assign c_fire   = in_valid && c_ready;
   assign d_fire   = c_valid_ff && d_ready;

   // whole seconds, then quotients by 60 and 3600 via reciprocals
   assign total = in_item.display[FRACTION_BITS +: SECS_W];
   assign p60   = SPLIT_PROD_W'(total) * RECIP60;
   assign p3600 = SPLIT_PROD_W'(total) * RECIP3600;

   // remainders from the registered quotients
   assign min_full = c_q60_ff - Q60_W'(c_hour_ff) * Q60_W'(SIXTY);
   assign sec_full = c_total_ff - SECS_W'(c_q60_ff) * SECS_W'(SIXTY);

   always_comb begin
      c_valid_in = c_valid_ff;
      if (c_fire) begin
         c_valid_in = 1'b1;
      end else if (d_ready) begin
         c_valid_in = 1'b0;
      end
      d_valid_in = d_valid_ff;
      if (d_fire) begin
         d_valid_in = 1'b1;
      end else if (out_ready) begin
         d_valid_in = 1'b0;
      end
      d_item_in.hour        = c_hour_ff;
      d_item_in.minute      = min_full[MIN_W-1:0];
      d_item_in.second      = sec_full[SEC_W-1:0];
      d_item_in.clock_valid = c_cv_ff;
   end

   // hold valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else begin
         c_valid_ff <= c_valid_in;
         d_valid_ff <= d_valid_in;
      end
   end

   // advance payloads
   always_ff @(posedge clock) begin
      if (c_fire) begin
         c_total_ff <= total;
         c_q60_ff   <= p60[SHIFT60 +: Q60_W];
         c_hour_ff  <= p3600[SHIFT3600 +: HOUR_W];
         c_cv_ff    <= in_item.clock_valid;
      end
      if (d_fire) begin
         d_item_ff <= d_item_in;
      end
   end

   assign out_valid = d_valid_ff;
   assign out_item  = d_item_ff;

endmodule

`default_nettype wire
